// ----- rtl/uds_sa_pkg.sv -----
// ----------------------------------------------------------------------------
// uds_sa_pkg
// Shared types and constants of the UDS SecurityAccess engine.
// ----------------------------------------------------------------------------
`default_nettype none

package uds_sa_pkg;

  localparam int unsigned KEY_BYTES = 4;

  localparam logic [31:0] LCG_SEED_INIT = 32'h1357_9BDF;
  localparam logic [31:0] LCG_MUL       = 32'd1664525;
  localparam logic [31:0] LCG_ADD       = 32'd1013904223;
  localparam logic [31:0] SEED_NONZERO  = 32'hA5A5_A5A5;
  localparam logic [7:0]  COUNT_MAX     = 8'hFF;

  localparam logic [7:0] NRC_SFNS     = 8'h12;
  localparam logic [7:0] NRC_LEN      = 8'h13;
  localparam logic [7:0] NRC_COND     = 8'h22;
  localparam logic [7:0] NRC_SEQ      = 8'h24;
  localparam logic [7:0] NRC_BADKEY   = 8'h35;
  localparam logic [7:0] NRC_ATTEMPTS = 8'h36;
  localparam logic [7:0] NRC_DELAY    = 8'h37;

  localparam logic [6:0] SUB_SEED_L1 = 7'd1;
  localparam logic [6:0] SUB_KEY_L1  = 7'd2;
  localparam logic [6:0] SUB_SEED_L3 = 7'd3;
  localparam logic [6:0] SUB_KEY_L3  = 7'd4;

  localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd0;
  localparam logic [1:0] CFG_LOCKOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_KEY_MODE      = 2'd2;

  localparam logic [7:0]  MAX_ATTEMPTS_RST  = 8'd3;
  localparam logic [15:0] LOCKOUT_TICKS_RST = 16'd10000;
  localparam logic        KEY_MODE_RST      = 1'b1;

  localparam logic [2:0] LEN_NEG = 3'd3;
  localparam logic [2:0] LEN_KEY = 3'd2;

  typedef enum logic [1:0] {
    CMD_REQ  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DROP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_POS  = 2'd1,
    KIND_NEG  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0]  max_attempts;
    logic [15:0] lockout_ticks;
    logic        key_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  sub_function;
    logic [7:0]  req_length;
    logic [31:0] key_value;
    logic [31:0] entropy;
    logic        access_allowed;
    logic        level_open;
  } req_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [2:0]  resp_length;
    logic [6:0]  resp_sub;
    logic [7:0]  nrc_code;
    logic [31:0] seed_out;
    logic [1:0]  unlock_level;
    logic        relocked;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/uds_sa_cfg.sv -----
// ----------------------------------------------------------------------------
// uds_sa_cfg
// Configuration registers: attempt limit, lockout length, key mode.
// ----------------------------------------------------------------------------
`default_nettype none

module uds_sa_cfg
  import uds_sa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_ATTEMPTS:  cfg_d.max_attempts  = cfg_data_i[7:0];
        CFG_LOCKOUT_TICKS: cfg_d.lockout_ticks = cfg_data_i;
        CFG_KEY_MODE:      cfg_d.key_mode      = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_attempts  <= MAX_ATTEMPTS_RST;
      cfg_q.lockout_ticks <= LOCKOUT_TICKS_RST;
      cfg_q.key_mode      <= KEY_MODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/uds_sa_core.sv -----
// ----------------------------------------------------------------------------
// uds_sa_core
// Security access state and the single-step request/tick/drop evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module uds_sa_core
  import uds_sa_pkg::*;
#(
  parameter int unsigned SEED_BYTES = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire req_t req_i,
  input  wire cfg_t cfg_i,
  output res_t      res_o
);

  localparam int unsigned SEED_SHIFT = 8 * (4 - SEED_BYTES);
  localparam logic [2:0]  LEN_SEED   = 3'(2 + SEED_BYTES);
  localparam logic [7:0]  LEN_KEYREQ = 8'(2 + KEY_BYTES);

  logic [31:0] lcg_q, lcg_d;
  logic [31:0] seed_q, seed_d;
  logic        pend_q, pend_d;
  logic [1:0]  plvl_q, plvl_d;
  logic [7:0]  fail_q, fail_d;
  logic [15:0] lock_q, lock_d;

  logic [31:0] lcg_mul;
  logic [31:0] lcg_mix;
  logic [31:0] expect_key;
  logic [6:0]  sns;
  logic        suppress;
  logic [1:0]  key_level;
  logic [7:0]  fail_inc;

  assign sns        = req_i.sub_function[6:0];
  assign suppress   = req_i.sub_function[7];
  assign key_level  = 2'(sns - 7'd1);
  assign lcg_mul    = lcg_q * LCG_MUL + LCG_ADD;
  assign lcg_mix    = ((lcg_mul ^ req_i.entropy) == 32'd0) ? SEED_NONZERO
                                                           : (lcg_mul ^ req_i.entropy);
  assign expect_key = cfg_i.key_mode ? ~seed_q : 32'd0;
  assign fail_inc   = (fail_q < COUNT_MAX) ? fail_q + 8'd1 : fail_q;

  always_comb begin
    lcg_d  = lcg_q;
    seed_d = seed_q;
    pend_d = pend_q;
    plvl_d = plvl_q;
    fail_d = fail_q;
    lock_d = lock_q;
    res_o  = '0;

    case (req_i.cmd)
      CMD_REQ: begin
        res_o.resp_kind   = KIND_NEG;
        res_o.resp_length = LEN_NEG;
        if (req_i.req_length < 8'd2) begin
          res_o.nrc_code = NRC_LEN;
        end else if (lock_q != 16'd0) begin
          res_o.nrc_code = NRC_DELAY;
        end else if (!req_i.access_allowed) begin
          res_o.nrc_code = NRC_COND;
        end else if (sns == SUB_SEED_L1 || sns == SUB_SEED_L3) begin
          if (req_i.req_length != 8'd2) begin
            res_o.nrc_code = NRC_LEN;
          end else begin
            res_o = '0;
            if (!req_i.level_open) begin
              lcg_d  = lcg_mix;
              seed_d = lcg_mix;
              pend_d = 1'b1;
              plvl_d = sns[1:0];
            end
            if (!suppress) begin
              res_o.resp_kind   = KIND_POS;
              res_o.resp_length = LEN_SEED;
              res_o.resp_sub    = sns;
              if (!req_i.level_open) begin
                res_o.seed_out = lcg_mix >> SEED_SHIFT;
              end
            end
          end
        end else if (sns == SUB_KEY_L1 || sns == SUB_KEY_L3) begin
          if (req_i.req_length != LEN_KEYREQ) begin
            res_o.nrc_code = NRC_LEN;
          end else if (!pend_q || plvl_q != key_level) begin
            res_o.nrc_code = NRC_SEQ;
          end else if (req_i.key_value != expect_key) begin
            pend_d         = 1'b0;
            plvl_d         = 2'd0;
            fail_d         = fail_inc;
            res_o.relocked = 1'b1;
            if (fail_inc >= cfg_i.max_attempts) begin
              lock_d         = cfg_i.lockout_ticks;
              res_o.nrc_code = NRC_ATTEMPTS;
            end else begin
              res_o.nrc_code = NRC_BADKEY;
            end
          end else begin
            pend_d             = 1'b0;
            plvl_d             = 2'd0;
            fail_d             = 8'd0;
            res_o              = '0;
            res_o.unlock_level = key_level;
            if (!suppress) begin
              res_o.resp_kind   = KIND_POS;
              res_o.resp_length = LEN_KEY;
              res_o.resp_sub    = sns;
            end
          end
        end else begin
          res_o.nrc_code = NRC_SFNS;
        end
      end
      CMD_TICK: begin
        if (lock_q != 16'd0) begin
          lock_d = lock_q - 16'd1;
          if (lock_q == 16'd1) begin
            fail_d = 8'd0;
          end
        end
      end
      CMD_DROP: begin
        pend_d = 1'b0;
        plvl_d = 2'd0;
        seed_d = 32'd0;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q  <= LCG_SEED_INIT;
      seed_q <= 32'd0;
      pend_q <= 1'b0;
      plvl_q <= 2'd0;
      fail_q <= 8'd0;
      lock_q <= 16'd0;
    end else if (fire_i) begin
      lcg_q  <= lcg_d;
      seed_q <= seed_d;
      pend_q <= pend_d;
      plvl_q <= plvl_d;
      fail_q <= fail_d;
      lock_q <= lock_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/uds_security_access_engine.sv -----
// ----------------------------------------------------------------------------
// uds_security_access_engine
// UDS SecurityAccess (0x27) server engine for levels 1 and 3.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per request:
//   a service request, a millisecond tick or a handshake drop. Every item
//   gives exactly one result on the output channel (out_valid_o /
//   out_stall_i); ticks and drops give a result with resp_kind zero.
//   The config channel (cfg_valid_i / cfg_ready_o) writes max_attempts,
//   lockout_ticks and key_mode by index; it is always ready.
//   An accepted item passes the input register, then the result register;
//   the single evaluation step with its constant LCG multiply sits between
//   them. Throughput: one item per cycle while the receiver does not stall.
//   When the receiver stalls, the result holds, the input register keeps
//   its item and in_stall_o rises once that register is occupied.
//   Reset clears the handshake, failure count, lockout and both registers'
//   valid bits, and loads the configuration defaults and LCG start word.
// ----------------------------------------------------------------------------
`default_nettype none

module uds_security_access_engine
  import uds_sa_pkg::*;
#(
  parameter int unsigned SEED_BYTES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  sub_function_i,
  input  wire logic [7:0]  req_length_i,
  input  wire logic [31:0] key_value_i,
  input  wire logic [31:0] entropy_i,
  input  wire logic        access_allowed_i,
  input  wire logic        level_open_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       resp_kind_o,
  output logic [2:0]       resp_length_o,
  output logic [6:0]       resp_sub_o,
  output logic [7:0]       nrc_code_o,
  output logic [31:0]      seed_out_o,
  output logic [1:0]       unlock_level_o,
  output logic             relocked_o
);

  cfg_t cfg;
  req_t req_q;
  res_t res, res_q;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic adv, in_acc, fire;

  assign cfg_ready_o = 1'b1;

  uds_sa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= '{cmd: cmd_i, sub_function: sub_function_i, req_length: req_length_i,
                 key_value: key_value_i, entropy: entropy_i,
                 access_allowed: access_allowed_i, level_open: level_open_i};
    end
    if (fire) begin
      res_q <= res;
    end
  end

  uds_sa_core #(
    .SEED_BYTES (SEED_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o    = out_valid_q;
  assign resp_kind_o    = res_q.resp_kind;
  assign resp_length_o  = res_q.resp_length;
  assign resp_sub_o     = res_q.resp_sub;
  assign nrc_code_o     = res_q.nrc_code;
  assign seed_out_o     = res_q.seed_out;
  assign unlock_level_o = res_q.unlock_level;
  assign relocked_o     = res_q.relocked;

endmodule

`default_nettype wire

// ----- rtl/uds_sa_checker.sv -----
// ----------------------------------------------------------------------------
// uds_sa_checker
// Port-level checks of the security access engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uds_sa_checker
  import uds_sa_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  resp_kind_o,
  input wire logic [2:0]  resp_length_o,
  input wire logic [7:0]  nrc_code_o,
  input wire logic [31:0] seed_out_o,
  input wire logic [1:0]  unlock_level_o,
  input wire logic        relocked_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(resp_kind_o)
      && $stable(nrc_code_o) && $stable(seed_out_o))
    else $error("stalled result changed");

  a_none_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resp_kind_o == KIND_NONE |-> resp_length_o == 3'd0
      && seed_out_o == 32'd0)
    else $error("empty response with length or seed");

  a_neg_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resp_kind_o == KIND_NEG |-> resp_length_o == LEN_NEG
      && nrc_code_o != 8'd0 && unlock_level_o == 2'd0)
    else $error("malformed negative response");

  a_relock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relocked_o |-> resp_kind_o == KIND_NEG
      && (nrc_code_o == NRC_BADKEY || nrc_code_o == NRC_ATTEMPTS))
    else $error("relock without bad key response");

endmodule

bind uds_security_access_engine uds_sa_checker u_uds_sa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .resp_kind_o    (resp_kind_o),
  .resp_length_o  (resp_length_o),
  .nrc_code_o     (nrc_code_o),
  .seed_out_o     (seed_out_o),
  .unlock_level_o (unlock_level_o),
  .relocked_o     (relocked_o)
);

`default_nettype wire

// ----- bench/tb_uds_security_access_engine.sv -----
// ----------------------------------------------------------------------------
// tb_uds_security_access_engine
// Self-checking bench for the UDS SecurityAccess engine. A behavioral
// model of the seed/key handshake, failure counter and lockout timer
// predicts one response per accepted request. Directed cases cover the
// request checks, suppressed replies, key mode zero and the register
// extremes. Random traffic then runs mostly seed/key exchanges with ticks,
// drops and malformed requests, under random idling on both channels and
// a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uds_security_access_engine;
  import uds_sa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEED_BYTES   = 4;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;
  localparam int unsigned DRAIN_TAIL   = 8;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [7:0] LEN_SEED_REQ = 8'd2;
  localparam logic [7:0] LEN_KEY_REQ  = 8'(2 + KEY_BYTES);
  localparam logic [1:0] LEVEL_NONE   = 2'd0;
  localparam logic [1:0] LEVEL_1      = 2'd1;
  localparam logic [1:0] LEVEL_3      = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_MAX_ATTEMPTS;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_TICK;
  logic [7:0]  sub_function_i = '0;
  logic [7:0]  req_length_i = '0;
  logic [31:0] key_value_i = '0;
  logic [31:0] entropy_i = '0;
  logic        access_allowed_i = 1'b0;
  logic        level_open_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  resp_kind_o;
  logic [2:0]  resp_length_o;
  logic [6:0]  resp_sub_o;
  logic [7:0]  nrc_code_o;
  logic [31:0] seed_out_o;
  logic [1:0]  unlock_level_o;
  logic        relocked_o;

  uds_security_access_engine #(
    .SEED_BYTES(SEED_BYTES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .sub_function_i  (sub_function_i),
    .req_length_i    (req_length_i),
    .key_value_i     (key_value_i),
    .entropy_i       (entropy_i),
    .access_allowed_i(access_allowed_i),
    .level_open_i    (level_open_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .resp_kind_o     (resp_kind_o),
    .resp_length_o   (resp_length_o),
    .resp_sub_o      (resp_sub_o),
    .nrc_code_o      (nrc_code_o),
    .seed_out_o      (seed_out_o),
    .unlock_level_o  (unlock_level_o),
    .relocked_o      (relocked_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // security state mirror
  logic [31:0] lcg_state      = LCG_SEED_INIT;
  logic [31:0] act_seed       = '0;
  logic        seed_pending   = 1'b0;
  logic [1:0]  pend_level     = LEVEL_NONE;
  logic [7:0]  fail_cnt       = '0;
  logic [15:0] lock_left      = '0;
  logic [7:0]  cfg_max_att    = MAX_ATTEMPTS_RST;
  logic [15:0] cfg_lock_ticks = LOCKOUT_TICKS_RST;
  logic        cfg_key_mode   = KEY_MODE_RST;

  res_t        replies_due[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned hold_off_req = 0;
  logic        in_up        = 1'b0;

  function automatic res_t negative(input logic [7:0] nrc, input logic rel);
    res_t r;
    r = '0;
    r.resp_kind   = KIND_NEG;
    r.resp_length = LEN_NEG;
    r.nrc_code    = nrc;
    r.relocked    = rel;
    return r;
  endfunction

  function automatic res_t predict_response(input req_t rq);
    res_t        r;
    logic [6:0]  sns;
    logic [1:0]  lvl;
    logic [31:0] want;
    r   = '0;
    sns = rq.sub_function[6:0];
    if (rq.cmd == CMD_TICK) begin
      if (lock_left != 0) begin
        lock_left = lock_left - 16'd1;
        if (lock_left == 0) fail_cnt = '0;
      end
      return r;
    end
    if (rq.cmd == CMD_DROP) begin
      seed_pending = 1'b0;
      pend_level   = LEVEL_NONE;
      act_seed     = '0;
      return r;
    end
    if (rq.cmd != CMD_REQ) return r;

    if (rq.req_length < LEN_SEED_REQ) return negative(NRC_LEN, 1'b0);
    if (lock_left != 0) return negative(NRC_DELAY, 1'b0);
    if (!rq.access_allowed) return negative(NRC_COND, 1'b0);

    if (sns == SUB_SEED_L1 || sns == SUB_SEED_L3) begin
      lvl = (sns == SUB_SEED_L1) ? LEVEL_1 : LEVEL_3;
      if (rq.req_length != LEN_SEED_REQ) return negative(NRC_LEN, 1'b0);
      if (!rq.level_open) begin
        lcg_state = lcg_state * LCG_MUL + LCG_ADD;
        lcg_state = lcg_state ^ rq.entropy;
        if (lcg_state == 0) lcg_state = SEED_NONZERO;
        act_seed     = lcg_state;
        seed_pending = 1'b1;
        pend_level   = lvl;
      end
      if (!rq.sub_function[7]) begin
        r.resp_kind   = KIND_POS;
        r.resp_length = 3'(2 + SEED_BYTES);
        r.resp_sub    = sns;
        if (!rq.level_open) r.seed_out = act_seed >> (8 * (4 - SEED_BYTES));
      end
      return r;
    end

    if (sns == SUB_KEY_L1 || sns == SUB_KEY_L3) begin
      lvl = (sns == SUB_KEY_L1) ? LEVEL_1 : LEVEL_3;
      if (rq.req_length != LEN_KEY_REQ) return negative(NRC_LEN, 1'b0);
      if (!seed_pending || pend_level != lvl) return negative(NRC_SEQ, 1'b0);
      want         = cfg_key_mode ? ~act_seed : '0;
      seed_pending = 1'b0;
      pend_level   = LEVEL_NONE;
      if (rq.key_value != want) begin
        if (fail_cnt != COUNT_MAX) fail_cnt = fail_cnt + 8'd1;
        if (fail_cnt >= cfg_max_att) begin
          lock_left = cfg_lock_ticks;
          return negative(NRC_ATTEMPTS, 1'b1);
        end
        return negative(NRC_BADKEY, 1'b1);
      end
      fail_cnt       = '0;
      r.unlock_level = lvl;
      if (!rq.sub_function[7]) begin
        r.resp_kind   = KIND_POS;
        r.resp_length = LEN_KEY;
        r.resp_sub    = sns;
      end
      return r;
    end

    return negative(NRC_SFNS, 1'b0);
  endfunction

  function automatic logic [31:0] right_key();
    return cfg_key_mode ? ~act_seed : '0;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic req_t make_req(input logic [1:0] cmd, input logic [7:0] sub,
                                    input logic [7:0] len, input logic [31:0] key,
                                    input logic [31:0] ent, input logic allowed,
                                    input logic open);
    req_t it;
    it.cmd            = cmd;
    it.sub_function   = sub;
    it.req_length     = len;
    it.key_value      = key;
    it.entropy        = ent;
    it.access_allowed = allowed;
    it.level_open     = open;
    return it;
  endfunction

  function automatic req_t random_item();
    req_t        it;
    int unsigned pick;
    logic        sup;
    pick = $urandom_range(0, 99);
    sup  = ($urandom_range(0, 7) == 0);
    it = make_req(CMD_REQ, {sup, ($urandom_range(0, 1) != 0) ? SUB_SEED_L1 : SUB_SEED_L3},
                  LEN_SEED_REQ, $urandom(), $urandom(), ($urandom_range(0, 19) != 0),
                  ($urandom_range(0, 9) == 0));
    if (pick < 10 || (lock_left != 0 && pick < 50)) begin
      it.cmd = CMD_TICK;
    end else if (pick < 13) begin
      it.cmd = CMD_DROP;
    end else if (pick < 15) begin
      it.cmd = CMD_UNUSED;
    end else if (pick < 25) begin
      it.sub_function = 8'($urandom());
      it.req_length   = ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
                                                      8'($urandom_range(0, 7));
    end else if (seed_pending && pick < 75) begin
      it.sub_function = {sup, (pend_level == LEVEL_1) ? SUB_KEY_L1 : SUB_KEY_L3};
      it.req_length   = LEN_KEY_REQ;
      if ($urandom_range(0, 4) < 3) it.key_value = right_key();
    end
    return it;
  endfunction

  task automatic issue_item(input req_t it);
    int unsigned gap;
    cmd_i            <= it.cmd;
    sub_function_i   <= it.sub_function;
    req_length_i     <= it.req_length;
    key_value_i      <= it.key_value;
    entropy_i        <= it.entropy;
    access_allowed_i <= it.access_allowed;
    level_open_i     <= it.level_open;
    in_valid_i       <= 1'b1;
    in_up = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    replies_due.push_back(predict_response(it));
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      in_up = 1'b0;
      gap = idle_len();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic ask_seed(input logic [7:0] sub, input logic [31:0] ent);
    issue_item(make_req(CMD_REQ, sub, LEN_SEED_REQ, $urandom(), ent, 1'b1, 1'b0));
  endtask

  task automatic offer_key(input logic [7:0] sub, input logic [31:0] key);
    issue_item(make_req(CMD_REQ, sub, LEN_KEY_REQ, key, $urandom(), 1'b1, 1'b0));
  endtask

  task automatic ctrl_item(input logic [1:0] cmd);
    issue_item(make_req(cmd, 8'($urandom()), 8'($urandom()), $urandom(), $urandom(),
                        1'b1, 1'b0));
  endtask

  task automatic wait_replies_done();
    if (in_up) begin
      in_valid_i <= 1'b0;
      in_up = 1'b0;
    end
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [7:0] ma, input logic [15:0] lt,
                                input logic km);
    wait_replies_done();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MAX_ATTEMPTS;
    cfg_data_i  <= {8'd0, ma};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_LOCKOUT_TICKS;
    cfg_data_i  <= lt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_KEY_MODE;
    cfg_data_i  <= {15'd0, km};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_max_att    = ma;
    cfg_lock_ticks = lt;
    cfg_key_mode   = km;
  endtask

  task automatic test_request_checks();
    write_settings(8'd2, 16'd3, 1'b1);
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L1}, 8'd0, 32'hFFFF_FFFF, '0, 1'b1, 1'b0));
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L1}, 8'd1, '0, '0, 1'b1, 1'b0));
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L1}, LEN_SEED_REQ, '0, '0, 1'b0, 1'b0));
    issue_item(make_req(CMD_REQ, 8'h00, LEN_SEED_REQ, '0, '0, 1'b1, 1'b0));
    issue_item(make_req(CMD_REQ, 8'hFF, 8'hFF, '0, '0, 1'b1, 1'b1));
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L1}, 8'd3, '0, '0, 1'b1, 1'b0));
    offer_key({1'b0, SUB_KEY_L1}, '0);
    // already unlocked: zero seed, then the same for level 3 suppressed
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L1}, LEN_SEED_REQ, '0, $urandom(),
                        1'b1, 1'b1));
    issue_item(make_req(CMD_REQ, {1'b1, SUB_SEED_L3}, LEN_SEED_REQ, '0, '0, 1'b1, 1'b1));
    ask_seed({1'b0, SUB_SEED_L1}, 32'hFFFF_FFFF);
    offer_key({1'b0, SUB_KEY_L3}, right_key());
    issue_item(make_req(CMD_REQ, {1'b0, SUB_KEY_L1}, 8'd5, right_key(), '0, 1'b1, 1'b0));
    offer_key({1'b0, SUB_KEY_L1}, right_key());
    // entropy cancels the LCG step, seed falls back to the nonzero pattern
    ask_seed({1'b0, SUB_SEED_L3}, lcg_state * LCG_MUL + LCG_ADD);
    ctrl_item(CMD_DROP);
    offer_key({1'b0, SUB_KEY_L3}, right_key());
    ask_seed({1'b1, SUB_SEED_L3}, $urandom());
    offer_key({1'b1, SUB_KEY_L3}, right_key());
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    offer_key({1'b0, SUB_KEY_L1}, ~right_key());
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    offer_key({1'b0, SUB_KEY_L1}, ~right_key());
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L1}, 8'd1, '0, '0, 1'b1, 1'b0));
    repeat (3) ctrl_item(CMD_TICK);
    ctrl_item(CMD_UNUSED);
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
  endtask

  task automatic test_key_mode_zero();
    write_settings(8'd3, 16'd5, 1'b0);
    ask_seed({1'b0, SUB_SEED_L3}, $urandom());
    offer_key({1'b0, SUB_KEY_L3}, '0);
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    offer_key({1'b0, SUB_KEY_L1}, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_limits();
    write_settings(8'd0, 16'd0, 1'b1);
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    offer_key({1'b0, SUB_KEY_L1}, ~right_key());
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    offer_key({1'b0, SUB_KEY_L1}, right_key());
    ctrl_item(CMD_TICK);
  endtask

  task automatic test_random_traffic(input int unsigned n, input logic [7:0] ma,
                                     input logic [15:0] lt, input logic km,
                                     input int unsigned tx_pct, input int unsigned rx_pct);
    write_settings(ma, lt, km);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) wait_replies_done();
      issue_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    hold_off_req = 150;
    repeat (24) issue_item(random_item());
    wait_replies_done();
  endtask

  task automatic test_fail_saturation();
    write_settings(8'd255, 16'd0, 1'b1);
    tx_idle_pct = 5;
    rx_idle_pct = 5;
    repeat (258) begin
      ask_seed({1'b0, SUB_SEED_L1}, $urandom());
      offer_key({1'b0, SUB_KEY_L1}, ~right_key());
    end
    ask_seed({1'b0, SUB_SEED_L3}, $urandom());
    offer_key({1'b0, SUB_KEY_L3}, right_key());
    ask_seed({1'b0, SUB_SEED_L3}, $urandom());
    offer_key({1'b0, SUB_KEY_L3}, ~right_key());
  endtask

  task automatic test_long_lockout();
    write_settings(8'd1, 16'd65535, 1'b1);
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    offer_key({1'b0, SUB_KEY_L1}, ~right_key());
    ask_seed({1'b0, SUB_SEED_L1}, $urandom());
    repeat (4) ctrl_item(CMD_TICK);
    ask_seed({1'b0, SUB_SEED_L3}, $urandom());
    issue_item(make_req(CMD_REQ, {1'b0, SUB_SEED_L3}, 8'd0, '0, '0, 1'b1, 1'b0));
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin : response_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (hold_off_req != 0) begin
          stall_left   = hold_off_req;
          hold_off_req = 0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
          stall_left = idle_len();
        end
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin : response_check
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.resp_kind    = resp_kind_o;
      got.resp_length  = resp_length_o;
      got.resp_sub     = resp_sub_o;
      got.nrc_code     = nrc_code_o;
      got.seed_out     = seed_out_o;
      got.unlock_level = unlock_level_o;
      got.relocked     = relocked_o;
      results_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: response %0d with no request outstanding: kind=%0d nrc=%h",
                   $time, results_seen, got.resp_kind, got.nrc_code);
      end else begin
        want = replies_due.pop_front();
        if (got.resp_kind !== want.resp_kind || got.resp_length !== want.resp_length ||
            got.resp_sub !== want.resp_sub || got.nrc_code !== want.nrc_code ||
            got.seed_out !== want.seed_out || got.unlock_level !== want.unlock_level ||
            got.relocked !== want.relocked) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: response %0d mismatch", $time, results_seen);
            $display("  expected kind=%0d len=%0d sub=%h nrc=%h seed=%h unlock=%0d relock=%0d",
                     want.resp_kind, want.resp_length, want.resp_sub, want.nrc_code,
                     want.seed_out, want.unlock_level, want.relocked);
            $display("  actual   kind=%0d len=%0d sub=%h nrc=%h seed=%h unlock=%0d relock=%0d",
                     got.resp_kind, got.resp_length, got.resp_sub, got.nrc_code,
                     got.seed_out, got.unlock_level, got.relocked);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("Verification failed");
    $finish;
  end

  initial begin : test_sequence
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_request_checks();
    test_key_mode_zero();
    test_zero_limits();
    test_random_traffic(300, 8'd1, 16'd1, 1'b1, 25, 25);
    test_backpressure();
    test_random_traffic(300, 8'($urandom_range(2, 5)), 16'($urandom_range(2, 40)),
                        1'b1, 30, 30);
    test_random_traffic(150, 8'd4, 16'd20, 1'b0, 0, 0);
    test_random_traffic(150, 8'd255, 16'd65535, 1'b1, 10, 40);
    test_fail_saturation();
    test_long_lockout();
    wait_replies_done();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
